/* hdl/dcd_pkg.sv */
// shared types, constants and helpers for the dilated direct convolution block
package dcd_pkg;

	// default sizes of the stores
	localparam int DEF_MAX_IN_CH  = 16;
	localparam int DEF_MAX_OUT_CH = 16;
	localparam int DEF_MAX_K      = 5;
	localparam int DEF_MAP_HEIGHT = 32;
	localparam int DEF_MAP_WIDTH  = 32;

	// field widths
	localparam int PIX_W     = 16;
	localparam int BIAS_W    = 32;
	localparam int PROD_W    = 32;
	localparam int ACC_W     = 48;
	localparam int VALUE_W   = 32;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 8;

	// tap position width: covers 31*7 + 4*7
	localparam int POS_W = 9;

	// request codes
	localparam logic [1:0] REQ_PIXEL   = 2'd0;
	localparam logic [1:0] REQ_WEIGHT  = 2'd1;
	localparam logic [1:0] REQ_BIAS    = 2'd2;
	localparam logic [1:0] REQ_COMPUTE = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DILATION_ROWS = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DILATION_COLS = 4'd7;

	// one input beat
	typedef struct packed {
		logic [1:0]                 req_type;
		logic [3:0]                 in_chan;
		logic [3:0]                 out_chan;
		logic [4:0]                 row;
		logic [4:0]                 col;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	// one result beat
	typedef struct packed {
		logic signed [ACC_W-1:0] out_value;
		logic                    out_of_range;
	} rsp_t;

	// saturate a loaded value to 16 bits
	function automatic logic signed [PIX_W-1:0] sat16(input logic signed [VALUE_W-1:0] v);
		logic signed [PIX_W-1:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[PIX_W-1:0];
		end
		return r;
	endfunction

endpackage

/* hdl/dcd_ram.sv */
// generic simple dual-port ram with registered read
module dcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/direct_conv2d_dilated.sv */
// top level of the strided, dilated direct 2d convolution engine
//
// Load beats (pixel, weight, bias) are written while busy stays low.
// A compute beat runs a check state, then issues one tap per cycle from the
// pixel and weight memories into a single shared multiply-accumulate, and the
// result is on done in the first cycle with busy low again. Each tap passes
// through the registered read port of its memory and the product register
// before it is accumulated. An invalid output channel or a tap outside the
// map is flagged by the check state alone, with busy high only in that state
// and done in the cycle after it.
// done is high for exactly one cycle and cannot be stalled. Bias entries read
// as zero until written; no clearing pass is needed after reset.
module direct_conv2d_dilated #(
	parameter int MAX_IN_CH  = dcd_pkg::DEF_MAX_IN_CH,
	parameter int MAX_OUT_CH = dcd_pkg::DEF_MAX_OUT_CH,
	parameter int MAX_K      = dcd_pkg::DEF_MAX_K,
	parameter int MAP_HEIGHT = dcd_pkg::DEF_MAP_HEIGHT,
	parameter int MAP_WIDTH  = dcd_pkg::DEF_MAP_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  dcd_pkg::req_t                    req,
	output logic                             done,
	output dcd_pkg::rsp_t                    result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dcd_pkg::CFG_DAT_W-1:0]    cfg_data
);

	import dcd_pkg::*;

	localparam int PIX_DEPTH = MAX_IN_CH * MAP_HEIGHT * MAP_WIDTH;
	localparam int WT_DEPTH  = MAX_OUT_CH * MAX_IN_CH * MAX_K * MAX_K;
	localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
	localparam int WT_AW     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
	localparam int OC_W      = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
	localparam int CH_W      = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
	localparam int KI_W      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int NOUT_W    = 7;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0] state_q;

	// configuration registers
	logic [4:0] in_channels_q, out_channels_q;
	logic [2:0] kernel_height_q, kernel_width_q;
	logic [2:0] stride_rows_q, stride_cols_q, dilation_rows_q, dilation_cols_q;

	// latched compute request
	logic [3:0] oc_q;
	logic [4:0] row_q, col_q;

	// loop state
	logic [CH_W-1:0]  nin_m1_q, ch_q;
	logic [KI_W-1:0]  kh_m1_q, kw_m1_q, i_q, j_q;
	logic [2:0]       dr_q, dc_q;
	logic [POS_W-1:0] base_r_q, base_c_q, pr_q, pc_q;

	// pipeline
	logic                     issue_s1, last_s1;
	logic                     vld_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	rsp_t                     result_q;

	logic [MAX_OUT_CH-1:0] bias_vld_q;

	logic accept, is_load_pix, is_load_wt, is_load_bias, is_compute;

	assign accept       = start && !busy;
	assign is_load_pix  = accept && (req.req_type == REQ_PIXEL);
	assign is_load_wt   = accept && (req.req_type == REQ_WEIGHT);
	assign is_load_bias = accept && (req.req_type == REQ_BIAS);
	assign is_compute   = accept && (req.req_type == REQ_COMPUTE);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// load decode with range checks
	logic                  pix_we, wt_we, bias_we;
	logic [PIX_AW-1:0]     pix_waddr, pix_raddr;
	logic [WT_AW-1:0]      wt_waddr, wt_raddr;
	logic [PIX_W-1:0]      load_sat;
	logic [PIX_W-1:0]      pix_rdata, wt_rdata;
	logic [BIAS_W-1:0]     bias_rdata;

	assign load_sat = sat16(req.value);

	assign pix_we = is_load_pix && (32'(req.in_chan) < MAX_IN_CH)
		&& (32'(req.row) < MAP_HEIGHT) && (32'(req.col) < MAP_WIDTH);
	assign wt_we = is_load_wt && (32'(req.in_chan) < MAX_IN_CH)
		&& (32'(req.out_chan) < MAX_OUT_CH)
		&& (32'(req.row) < MAX_K) && (32'(req.col) < MAX_K);
	assign bias_we = is_load_bias && (32'(req.out_chan) < MAX_OUT_CH);

	assign pix_waddr = PIX_AW'((32'(req.in_chan) * MAP_HEIGHT + 32'(req.row)) * MAP_WIDTH
		+ 32'(req.col));
	assign wt_waddr = WT_AW'(((32'(req.out_chan) * MAX_IN_CH + 32'(req.in_chan)) * MAX_K
		+ 32'(req.row)) * MAX_K + 32'(req.col));

	// tap addresses from the loop counters
	assign pix_raddr = PIX_AW'((32'(ch_q) * MAP_HEIGHT + 32'(pr_q)) * MAP_WIDTH + 32'(pc_q));
	assign wt_raddr = WT_AW'(((32'(oc_q) * MAX_IN_CH + 32'(ch_q)) * MAX_K + 32'(i_q)) * MAX_K
		+ 32'(j_q));

	dcd_ram #(.WIDTH(PIX_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (load_sat),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	dcd_ram #(.WIDTH(PIX_W), .DEPTH(WT_DEPTH)) u_wt_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (load_sat),
		.raddr (wt_raddr),
		.rdata (wt_rdata)
	);

	dcd_ram #(.WIDTH(BIAS_W), .DEPTH(MAX_OUT_CH)) u_bias_ram (
		.clk   (clk),
		.we    (bias_we),
		.waddr (OC_W'(req.out_chan)),
		.wdata (req.value),
		.raddr (OC_W'(req.out_chan)),
		.rdata (bias_rdata)
	);

	// check stage: clamp registers, base positions and last-tap bounds
	logic [CH_W-1:0]   nin_m1_c;
	logic [NOUT_W-1:0] nout_c;
	logic [KI_W-1:0]   kh_m1_c, kw_m1_c;
	logic [2:0]        sr_c, sc_c, dr_c, dc_c;
	logic [POS_W-1:0]  base_r_c, base_c_c, last_r_c, last_c_c;
	logic              bad_c;
	logic signed [ACC_W-1:0] bias_c;

	always_comb begin
		if (in_channels_q == 5'd0) begin
			nin_m1_c = '0;
		end else if (32'(in_channels_q) > MAX_IN_CH) begin
			nin_m1_c = CH_W'(MAX_IN_CH - 1);
		end else begin
			nin_m1_c = CH_W'(in_channels_q - 5'd1);
		end
		if (out_channels_q == 5'd0) begin
			nout_c = NOUT_W'(1);
		end else if (32'(out_channels_q) > MAX_OUT_CH) begin
			nout_c = NOUT_W'(MAX_OUT_CH);
		end else begin
			nout_c = NOUT_W'(out_channels_q);
		end
		if (kernel_height_q == 3'd0) begin
			kh_m1_c = '0;
		end else if (32'(kernel_height_q) > MAX_K) begin
			kh_m1_c = KI_W'(MAX_K - 1);
		end else begin
			kh_m1_c = KI_W'(kernel_height_q - 3'd1);
		end
		if (kernel_width_q == 3'd0) begin
			kw_m1_c = '0;
		end else if (32'(kernel_width_q) > MAX_K) begin
			kw_m1_c = KI_W'(MAX_K - 1);
		end else begin
			kw_m1_c = KI_W'(kernel_width_q - 3'd1);
		end
		sr_c = (stride_rows_q == 3'd0) ? 3'd1 : stride_rows_q;
		sc_c = (stride_cols_q == 3'd0) ? 3'd1 : stride_cols_q;
		dr_c = (dilation_rows_q == 3'd0) ? 3'd1 : dilation_rows_q;
		dc_c = (dilation_cols_q == 3'd0) ? 3'd1 : dilation_cols_q;
		base_r_c = POS_W'(row_q) * POS_W'(sr_c);
		base_c_c = POS_W'(col_q) * POS_W'(sc_c);
		last_r_c = base_r_c + POS_W'(kh_m1_c) * POS_W'(dr_c);
		last_c_c = base_c_c + POS_W'(kw_m1_c) * POS_W'(dc_c);
		bad_c = (NOUT_W'(oc_q) >= nout_c) || (32'(last_r_c) >= MAP_HEIGHT)
			|| (32'(last_c_c) >= MAP_WIDTH);
		bias_c = bias_vld_q[OC_W'(oc_q)]
			? ACC_W'(signed'(bias_rdata)) : '0;
	end

	// last tap of the loop nest
	logic last_issue;
	assign last_issue = (j_q == kw_m1_q) && (i_q == kh_m1_q) && (ch_q == nin_m1_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_channels_q   <= 5'd1;
			out_channels_q  <= 5'd1;
			kernel_height_q <= 3'd3;
			kernel_width_q  <= 3'd3;
			stride_rows_q   <= 3'd1;
			stride_cols_q   <= 3'd1;
			dilation_rows_q <= 3'd1;
			dilation_cols_q <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IN_CHANNELS:   in_channels_q   <= cfg_data[4:0];
				REG_OUT_CHANNELS:  out_channels_q  <= cfg_data[4:0];
				REG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[2:0];
				REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data[2:0];
				REG_STRIDE_ROWS:   stride_rows_q   <= cfg_data[2:0];
				REG_STRIDE_COLS:   stride_cols_q   <= cfg_data[2:0];
				REG_DILATION_ROWS: dilation_rows_q <= cfg_data[2:0];
				REG_DILATION_COLS: dilation_cols_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// bias valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_vld_q <= '0;
		end else if (bias_we) begin
			bias_vld_q[OC_W'(req.out_chan)] <= 1'b1;
		end
	end

	// sequencer and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issue_s1 <= 1'b0;
			last_s1  <= 1'b0;
			vld_s2   <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
			nin_m1_q <= '0;
			kh_m1_q  <= '0;
			kw_m1_q  <= '0;
			dr_q     <= 3'd1;
			dc_q     <= 3'd1;
			base_r_q <= '0;
			base_c_q <= '0;
			ch_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			pr_q     <= '0;
			pc_q     <= '0;
		end else begin
			issue_s1 <= (state_q == ST_RUN);
			last_s1  <= (state_q == ST_RUN) && last_issue;
			vld_s2   <= issue_s1;
			last_s2  <= last_s1;
			done_q   <= ((state_q == ST_CHECK) && bad_c) || ((state_q == ST_DRAIN) && last_s2);
			unique case (state_q)
				ST_IDLE: begin
					if (is_compute) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					nin_m1_q <= nin_m1_c;
					kh_m1_q  <= kh_m1_c;
					kw_m1_q  <= kw_m1_c;
					dr_q     <= dr_c;
					dc_q     <= dc_c;
					base_r_q <= base_r_c;
					base_c_q <= base_c_c;
					ch_q     <= '0;
					i_q      <= '0;
					j_q      <= '0;
					pr_q     <= base_r_c;
					pc_q     <= base_c_c;
					if (bad_c) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (j_q == kw_m1_q) begin
						j_q  <= '0;
						pc_q <= base_c_q;
						if (i_q == kh_m1_q) begin
							i_q  <= '0;
							pr_q <= base_r_q;
							ch_q <= ch_q + 1'b1;
						end else begin
							i_q  <= i_q + 1'b1;
							pr_q <= pr_q + POS_W'(dr_q);
						end
					end else begin
						j_q  <= j_q + 1'b1;
						pc_q <= pc_q + POS_W'(dc_q);
					end
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (last_s2) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (is_compute) begin
			oc_q  <= req.out_chan;
			row_q <= req.row;
			col_q <= req.col;
		end
	end

	// multiply-accumulate datapath and result register
	always_ff @(posedge clk) begin
		prod_s2 <= signed'(pix_rdata) * signed'(wt_rdata);
		if (state_q == ST_CHECK) begin
			acc_q <= bias_c;
			if (bad_c) begin
				result_q.out_value    <= '0;
				result_q.out_of_range <= 1'b1;
			end
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
			if (last_s2) begin
				result_q.out_value    <= acc_q + ACC_W'(prod_s2);
				result_q.out_of_range <= 1'b0;
			end
		end
	end

endmodule

/* test/direct_conv2d_dilated_test.sv */
// testbench for direct_conv2d_dilated: store loads, checked convolutions and register sweeps
module direct_conv2d_dilated_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dcd_pkg::*;

	localparam int N_IN        = DEF_MAX_IN_CH;
	localparam int N_OUT       = DEF_MAX_OUT_CH;
	localparam int KMAX        = DEF_MAX_K;
	localparam int MAP_H       = DEF_MAP_HEIGHT;
	localparam int MAP_W       = DEF_MAP_WIDTH;
	localparam int N_REGS      = 8;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 40;
	localparam int N_PHASES    = 14;
	localparam int SETTLE      = 8;

	// shadow of the stores and registers, and the queue of predicted sums
	class conv_checker;
		bit signed [PIX_W-1:0]  pixel_mem  [N_IN][MAP_H][MAP_W];
		bit                     pixel_set  [N_IN][MAP_H][MAP_W];
		bit signed [PIX_W-1:0]  weight_mem [N_OUT][N_IN][KMAX][KMAX];
		bit                     weight_set [N_OUT][N_IN][KMAX][KMAX];
		bit signed [BIAS_W-1:0] bias_mem   [N_OUT];
		bit [CFG_DAT_W-1:0]     regs       [N_REGS];
		rsp_t                   pending_sums [$];
		int                     errors;

		function new();
			foreach (regs[k]) regs[k] = 1;
			regs[REG_KERNEL_HEIGHT] = 3;
			regs[REG_KERNEL_WIDTH] = 3;
			errors = 0;
		endfunction

		// effective register value: zero acts as one, sizes clip at the store bounds
		function int shape(logic [CFG_IDX_W-1:0] idx);
			int v;
			int hi;
			if (idx == REG_IN_CHANNELS || idx == REG_OUT_CHANNELS) begin
				v = regs[idx] & 31;
			end else begin
				v = regs[idx] & 7;
			end
			case (idx)
				REG_IN_CHANNELS: hi = N_IN;
				REG_OUT_CHANNELS: hi = N_OUT;
				REG_KERNEL_HEIGHT, REG_KERNEL_WIDTH: hi = KMAX;
				default: hi = 7;
			endcase
			if (v < 1) v = 1;
			if (v > hi) v = hi;
			return v;
		endfunction

		function int tap_row(req_t q, int i);
			return int'(q.row) * shape(REG_STRIDE_ROWS) + i * shape(REG_DILATION_ROWS);
		endfunction

		function int tap_col(req_t q, int j);
			return int'(q.col) * shape(REG_STRIDE_COLS) + j * shape(REG_DILATION_COLS);
		endfunction

		// a compute reads the stores only for a valid channel with every tap on the map
		function bit reads_taps(req_t q);
			return int'(q.out_chan) < shape(REG_OUT_CHANNELS)
				&& tap_row(q, shape(REG_KERNEL_HEIGHT) - 1) < MAP_H
				&& tap_col(q, shape(REG_KERNEL_WIDTH) - 1) < MAP_W;
		endfunction

		function bit signed [PIX_W-1:0] clip16(logic signed [VALUE_W-1:0] v);
			if (v > 32767) return 16'sh7fff;
			if (v < -32768) return 16'sh8000;
			return v[PIX_W-1:0];
		endfunction

		function rsp_t conv_sum(req_t q);
			rsp_t r;
			longint acc;
			r.out_value = '0;
			r.out_of_range = 1'b1;
			if (!reads_taps(q)) return r;
			acc = bias_mem[q.out_chan];
			for (int ch = 0; ch < shape(REG_IN_CHANNELS); ch++) begin
				for (int i = 0; i < shape(REG_KERNEL_HEIGHT); i++) begin
					for (int j = 0; j < shape(REG_KERNEL_WIDTH); j++) begin
						acc += longint'(pixel_mem[ch][tap_row(q, i)][tap_col(q, j)])
							* longint'(weight_mem[q.out_chan][ch][i][j]);
					end
				end
			end
			r.out_value = acc[ACC_W-1:0];
			r.out_of_range = 1'b0;
			return r;
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			if (idx < N_REGS) regs[idx] = data;
		endfunction

		function void note_input(req_t q);
			case (q.req_type)
				REQ_PIXEL: begin
					pixel_mem[q.in_chan][q.row][q.col] = clip16(q.value);
					pixel_set[q.in_chan][q.row][q.col] = 1'b1;
				end
				REQ_WEIGHT: begin
					if (q.row < KMAX && q.col < KMAX) begin
						weight_mem[q.out_chan][q.in_chan][q.row][q.col] = clip16(q.value);
						weight_set[q.out_chan][q.in_chan][q.row][q.col] = 1'b1;
					end
				end
				REQ_BIAS: begin
					bias_mem[q.out_chan] = q.value;
				end
				default: begin
					pending_sums.push_back(conv_sum(q));
				end
			endcase
		endfunction

		function void flag(string what, rsp_t want, rsp_t got);
			errors++;
			if (errors <= 10)
				$display("%0t mismatch in %s: expected value %0d range %0b, got value %0d range %0b",
					$time, what, want.out_value, want.out_of_range, got.out_value, got.out_of_range);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_sums.size() == 0) begin
				flag("result with no compute pending", '0, got);
				return;
			end
			want = pending_sums.pop_front();
			if (got.out_value !== want.out_value) flag("out_value", want, got);
			if (got.out_of_range !== want.out_of_range) flag("out_of_range", want, got);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	req_t                 req       = '0;
	logic                 done;
	rsp_t                 result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;

	conv_checker chk;
	int          quiet_cycles = 0;
	int          idle_pct     = 0;
	int          items_sent   = 0;
	int          idle_mix [4] = '{0, 69, 0, 8};

	direct_conv2d_dilated dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// beat monitor: results against predictions, accepted beats into the shadow
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) chk.check_result(result);
			if (start && !busy) chk.note_input(req);
			if (cfg_valid && cfg_ready) chk.note_config(cfg_index, cfg_data);
			if (done || (start && !busy) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic req_t noise_req();
		req_t q;
		q.req_type = 2'($urandom_range(3));
		q.in_chan = 4'($urandom_range(15));
		q.out_chan = 4'($urandom_range(15));
		q.row = 5'($urandom_range(31));
		q.col = 5'($urandom_range(31));
		q.value = $urandom;
		return q;
	endfunction

	// mix of full-range, in-range and saturation-edge load values
	function automatic logic signed [VALUE_W-1:0] load_value();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4) return $urandom;
		if (pick < 8) return int'($urandom_range(65535)) - 32768;
		case ($urandom_range(5))
			0: return 32767;
			1: return -32768;
			2: return 32768;
			3: return -32769;
			4: return 32'sh7fffffff;
			default: return 32'sh80000000;
		endcase
	endfunction

	// last output position whose window still fits on the map, or -1
	function automatic int last_start(int k, int d, int s, int span);
		int reach;
		reach = (k - 1) * d;
		return reach >= span ? -1 : (span - 1 - reach) / s;
	endfunction

	// one request beat, with an optional random gap in front
	task automatic send(input req_t q);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			req = noise_req();
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start = 1'b1;
		req = q;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		if (q.req_type != REQ_WEIGHT || (q.row < KMAX && q.col < KMAX)) items_sent++;
	endtask

	// hold off until every sum has come back and the block is quiet
	task automatic settle();
		start = 1'b0;
		req = noise_req();
		while (chk.pending_sums.size() != 0 || busy) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int field);
		logic [CFG_DAT_W-1:0] data;
		data = CFG_DAT_W'($urandom);
		if (idx == REG_IN_CHANNELS || idx == REG_OUT_CHANNELS) begin
			data[4:0] = field[4:0];
		end else begin
			data[2:0] = field[2:0];
		end
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input int in_ch, input int out_ch, input int kh, input int kw,
			input int sr, input int sc, input int dr, input int dc);
		settle();
		write_reg(REG_IN_CHANNELS, in_ch);
		write_reg(REG_OUT_CHANNELS, out_ch);
		write_reg(REG_KERNEL_HEIGHT, kh);
		write_reg(REG_KERNEL_WIDTH, kw);
		write_reg(REG_STRIDE_ROWS, sr);
		write_reg(REG_STRIDE_COLS, sc);
		write_reg(REG_DILATION_ROWS, dr);
		write_reg(REG_DILATION_COLS, dc);
		// index past the register list, must be ignored
		write_reg(CFG_IDX_W'($urandom_range(15, N_REGS)), $urandom);
	endtask

	// compute beat, preceded by loads for any window entry never written
	task automatic run_conv(input req_t q);
		req_t ld;
		if (chk.reads_taps(q)) begin
			for (int ch = 0; ch < chk.shape(REG_IN_CHANNELS); ch++) begin
				for (int i = 0; i < chk.shape(REG_KERNEL_HEIGHT); i++) begin
					for (int j = 0; j < chk.shape(REG_KERNEL_WIDTH); j++) begin
						if (!chk.pixel_set[ch][chk.tap_row(q, i)][chk.tap_col(q, j)]) begin
							ld = noise_req();
							ld.req_type = REQ_PIXEL;
							ld.in_chan = 4'(ch);
							ld.row = 5'(chk.tap_row(q, i));
							ld.col = 5'(chk.tap_col(q, j));
							ld.value = load_value();
							send(ld);
						end
						if (!chk.weight_set[q.out_chan][ch][i][j]) begin
							ld = noise_req();
							ld.req_type = REQ_WEIGHT;
							ld.out_chan = q.out_chan;
							ld.in_chan = 4'(ch);
							ld.row = 5'(i);
							ld.col = 5'(j);
							ld.value = load_value();
							send(ld);
						end
					end
				end
			end
		end
		send(q);
	endtask

	// mostly in-bounds windows, sometimes anywhere; bias refreshed now and then
	task automatic conv_sequence();
		req_t q;
		req_t ld;
		int top_r;
		int top_c;
		q = noise_req();
		q.req_type = REQ_COMPUTE;
		if ($urandom_range(99) < 85) begin
			q.out_chan = 4'($urandom_range(chk.shape(REG_OUT_CHANNELS) - 1));
			top_r = last_start(chk.shape(REG_KERNEL_HEIGHT), chk.shape(REG_DILATION_ROWS),
				chk.shape(REG_STRIDE_ROWS), MAP_H);
			top_c = last_start(chk.shape(REG_KERNEL_WIDTH), chk.shape(REG_DILATION_COLS),
				chk.shape(REG_STRIDE_COLS), MAP_W);
			if (top_r >= 0) q.row = 5'(($urandom_range(4) == 0) ? top_r : $urandom_range(top_r));
			if (top_c >= 0) q.col = 5'(($urandom_range(4) == 0) ? top_c : $urandom_range(top_c));
		end
		if ($urandom_range(99) < 30) begin
			ld = noise_req();
			ld.req_type = REQ_BIAS;
			ld.out_chan = q.out_chan;
			send(ld);
		end
		run_conv(q);
	endtask

	task automatic random_phase(input int budget);
		req_t q;
		int stop_at;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 70) begin
				conv_sequence();
			end else begin
				q = noise_req();
				if ($urandom_range(1) == 0) q.value = load_value();
				if (q.req_type == REQ_COMPUTE) begin
					run_conv(q);
				end else begin
					send(q);
				end
			end
			// occasional full drain in the middle of a phase
			if ($urandom_range(99) < 2) settle();
		end
	endtask

	// corners of every field under the reset register values
	task automatic directed();
		req_t q;
		q = '0;
		// pixel loads saturating both ways, at opposite map corners
		q.req_type = REQ_PIXEL;
		q.value = 32'sh7fffffff;
		send(q);
		q.in_chan = 15;
		q.row = 31;
		q.col = 31;
		q.value = 32'sh80000000;
		send(q);
		// weight at the far tap corner, then one outside the tap range
		q.req_type = REQ_WEIGHT;
		q.out_chan = 15;
		q.row = 4;
		q.col = 4;
		q.value = -32769;
		send(q);
		q.row = 31;
		q.col = 5;
		q.value = 7;
		send(q);
		// bias extremes
		q.req_type = REQ_BIAS;
		q.out_chan = 0;
		q.value = 32'sh7fffffff;
		send(q);
		q.out_chan = 15;
		q.value = 32'sh80000000;
		send(q);
		// channel beyond out_channels, then windows past the bottom and right edges
		q.req_type = REQ_COMPUTE;
		q.out_chan = 1;
		q.row = 0;
		q.col = 0;
		send(q);
		q.out_chan = 0;
		q.row = 30;
		send(q);
		q.row = 0;
		q.col = 31;
		send(q);
		// full window at the origin
		q.col = 0;
		run_conv(q);
	endtask

	initial begin
		chk = new();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		directed();
		for (int p = 0; p < N_PHASES; p++) begin
			idle_pct = idle_mix[p % 4];
			case (p)
				0: configure(0, 0, 0, 0, 0, 0, 0, 0);
				1: configure(31, 31, 7, 7, 7, 7, 7, 7);
				2: configure(4, 3, 5, 5, 4, 4, 4, 4);
				3: configure(1, 16, 1, 1, 1, 1, 1, 1);
				default: begin
					configure(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4),
						($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(5),
						$urandom_range(7), $urandom_range(7),
						$urandom_range(7), $urandom_range(7),
						$urandom_range(7), $urandom_range(7));
				end
			endcase
			random_phase(PHASE_ITEMS);
		end
		settle();
		if (chk.errors == 0 && chk.pending_sums.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/dcd_pkg.sv
hdl/dcd_ram.sv
hdl/direct_conv2d_dilated.sv
test/direct_conv2d_dilated_test.sv
